// ===== rtl/core/cdfd_pkg.sv =====
// Shared types, constants and the CRC step for the frame deframer.
package cdfd_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int PL_AW       = $clog2(MAX_PAYLOAD);
  localparam int ST_AW       = PL_AW + 1;

  localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND = 8'h5A;
  localparam logic [15:0] CRC_SEED    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h8408;

  localparam logic [7:0] ACCEPT_TYPE_RST   = 8'h01;
  localparam logic [6:0] ACCEPT_LENGTH_RST = 7'd64;

  // result status codes
  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // register indexes
  localparam logic REG_ACCEPT_TYPE   = 1'b0;
  localparam logic REG_ACCEPT_LENGTH = 1'b1;

  typedef struct packed {
    logic             en;
    logic [ST_AW-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       bank;
    logic [7:0] ftype;
    logic [6:0] flen;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic [7:0] frame_type;
    logic [6:0] frame_length;
    logic       last;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/cdfd_front.sv =====
// Frame parser: sync hunt, header, payload capture, CRC and end-of-frame decision.
module cdfd_front import cdfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_rx_byte,
  output logic       in_full,
  input  logic [7:0] accept_type,
  input  logic [6:0] accept_length,
  input  logic       cmdq_full,
  output logic       cmd_push,
  output cmd_t       cmd,
  output store_wr_t  wr,
  input  bank_rel_t  rel
);

  localparam logic [2:0] PH_HUNT0   = 3'd0;
  localparam logic [2:0] PH_HUNT1   = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CRC0    = 3'd5;
  localparam logic [2:0] PH_CRC1    = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  held_type_r, held_type_nxt;
  logic [6:0]  held_length_r, held_length_nxt;
  logic [6:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  crc_low_r, crc_low_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        wr_bank_r, wr_bank_nxt;
  logic [1:0]  busy_r, busy_nxt;

  logic        acc;
  logic [15:0] crc_in, crc_new;
  logic [6:0]  count_inc;
  logic        crc_good, match;

  assign in_full = ((phase_r == PH_CRC1) && cmdq_full) ||
                   ((phase_r == PH_PAYLOAD) && busy_r[wr_bank_r]);
  assign acc       = in_push && !in_full;
  assign crc_in    = (phase_r == PH_TYPE) ? CRC_SEED : crc_r;
  assign crc_new   = crc_byte(crc_in, in_rx_byte);
  assign count_inc = byte_count_r + 7'd1;
  assign crc_good  = ({in_rx_byte, crc_low_r} == crc_r);
  assign match     = (held_type_r == accept_type) && (held_length_r == accept_length);

  always_comb begin
    phase_nxt       = phase_r;
    held_type_nxt   = held_type_r;
    held_length_nxt = held_length_r;
    byte_count_nxt  = byte_count_r;
    crc_low_nxt     = crc_low_r;
    crc_nxt         = crc_r;
    wr_bank_nxt     = wr_bank_r;
    busy_nxt        = busy_r;
    cmd_push        = 1'b0;
    cmd.kind        = ST_CRC_ERR;
    cmd.bank        = wr_bank_r;
    cmd.ftype       = held_type_r;
    cmd.flen        = held_length_r;
    wr.en           = 1'b0;
    wr.addr         = {wr_bank_r, byte_count_r[PL_AW-1:0]};
    wr.data         = in_rx_byte;

    if (rel.en) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (acc) begin
      case (phase_r)
        PH_HUNT0: begin
          if (in_rx_byte == SYNC_FIRST) phase_nxt = PH_HUNT1;
        end
        PH_HUNT1: begin
          if (in_rx_byte == SYNC_SECOND) phase_nxt = PH_TYPE;
          else if (in_rx_byte != SYNC_FIRST) phase_nxt = PH_HUNT0;
        end
        PH_TYPE: begin
          held_type_nxt = in_rx_byte;
          crc_nxt       = crc_new;
          phase_nxt     = PH_LEN;
        end
        PH_LEN: begin
          // drop oversized frames and hunt again
          if ({1'b0, in_rx_byte} > 9'(MAX_PAYLOAD)) begin
            phase_nxt = PH_HUNT0;
          end else begin
            held_length_nxt = in_rx_byte[6:0];
            crc_nxt         = crc_new;
            byte_count_nxt  = 7'd0;
            phase_nxt       = (in_rx_byte == 8'd0) ? PH_CRC0 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          wr.en          = 1'b1;
          crc_nxt        = crc_new;
          byte_count_nxt = count_inc;
          if (count_inc >= held_length_r) phase_nxt = PH_CRC0;
        end
        PH_CRC0: begin
          crc_low_nxt = in_rx_byte;
          phase_nxt   = PH_CRC1;
        end
        PH_CRC1: begin
          phase_nxt = PH_HUNT0;
          if (!crc_good) begin
            cmd_push = 1'b1;
            cmd.kind = ST_CRC_ERR;
          end else if (!match) begin
            cmd_push = 1'b1;
            cmd.kind = ST_IGNORED;
          end else if (held_length_r != 7'd0) begin
            // hand the filled bank to the back end and swap
            cmd_push            = 1'b1;
            cmd.kind            = ST_PAYLOAD;
            busy_nxt[wr_bank_r] = 1'b1;
            wr_bank_nxt         = ~wr_bank_r;
          end
        end
        default: begin
          phase_nxt = PH_HUNT0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT0;
      held_type_r   <= 8'd0;
      held_length_r <= 7'd0;
      byte_count_r  <= 7'd0;
      crc_low_r     <= 8'd0;
      crc_r         <= CRC_SEED;
      wr_bank_r     <= 1'b0;
      busy_r        <= 2'b00;
    end else begin
      phase_r       <= phase_nxt;
      held_type_r   <= held_type_nxt;
      held_length_r <= held_length_nxt;
      byte_count_r  <= byte_count_nxt;
      crc_low_r     <= crc_low_nxt;
      crc_r         <= crc_nxt;
      wr_bank_r     <= wr_bank_nxt;
      busy_r        <= busy_nxt;
    end
  end

endmodule

// ===== rtl/core/cdfd_cmdq.sv =====
// Two-entry command queue between the parser and the result sequencer.
module cdfd_cmdq import cdfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t       ent_r [0:1];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/cdfd_back.sv =====
// Payload store (two banks) and the sequencer that turns commands into results.
module cdfd_back import cdfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  store_wr_t wr,
  input  cmd_t      cmd,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  output bank_rel_t rel,
  output logic      res_push,
  output result_t   res,
  input  logic      res_full
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_WAIT = 2'd2;

  logic [7:0] store_mem [0:2*MAX_PAYLOAD-1];
  logic [7:0] rd_data_r;

  logic [1:0]       state_r, state_nxt;
  cmd_t             cur_r, cur_nxt;
  logic [PL_AW-1:0] idx_r, idx_nxt;
  logic             rd_en;
  logic [ST_AW-1:0] rd_addr;
  logic             is_last;

  assign rd_addr = {cur_r.bank, idx_r};
  assign is_last = (7'(idx_r) + 7'd1 == cur_r.flen);

  always_ff @(posedge clk) begin
    if (wr.en) store_mem[wr.addr] <= wr.data;
    if (rd_en) rd_data_r <= store_mem[rd_addr];
  end

  always_comb begin
    state_nxt        = state_r;
    cur_nxt          = cur_r;
    idx_nxt          = idx_r;
    cmd_pop          = 1'b0;
    rd_en            = 1'b0;
    rel.en           = 1'b0;
    rel.bank         = cur_r.bank;
    res_push         = 1'b0;
    res.status       = cmd.kind;
    res.payload_byte = 8'd0;
    res.byte_index   = 6'd0;
    res.frame_type   = cmd.ftype;
    res.frame_length = cmd.flen;
    res.last         = 1'b1;

    case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.kind == ST_PAYLOAD) begin
            cmd_pop   = 1'b1;
            cur_nxt   = cmd;
            idx_nxt   = '0;
            state_nxt = B_READ;
          end else if (!res_full) begin
            cmd_pop  = 1'b1;
            res_push = 1'b1;
          end
        end
      end
      B_READ: begin
        rd_en     = 1'b1;
        state_nxt = B_WAIT;
      end
      B_WAIT: begin
        res.status       = ST_PAYLOAD;
        res.payload_byte = rd_data_r;
        res.byte_index   = 6'(idx_r);
        res.frame_type   = cur_r.ftype;
        res.frame_length = cur_r.flen;
        res.last         = is_last;
        // hold the beat until the output queue has room
        if (!res_full) begin
          res_push = 1'b1;
          if (is_last) begin
            rel.en    = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_r + PL_AW'(1);
            state_nxt = B_READ;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
  end

endmodule

// ===== rtl/core/cdfd_outq.sv =====
// Four-entry result queue feeding the output ports.
module cdfd_outq import cdfd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_res,
  output logic    full,
  input  logic    pop,
  output result_t head,
  output logic    empty
);

  result_t    ent_r [0:3];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign head    = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 3'd1;
        2'b01:   cnt_r <= cnt_r - 3'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/crc_checked_frame_deframer_unit.sv =====
// Top level of the CRC-checked frame deframer.
// Bytes are pushed one per beat and the parser takes one byte every clock while in_full is low.
// It hunts for the sync pair A5 5A, reads type, length (up to 64), payload and a little-endian
// reflected CRC-16/CCITT. After the second CRC byte the block queues one result: a CRC mismatch,
// a good but ignored frame, or, for a frame matching accept_type and accept_length, a run of
// payload bytes with last set on the final one (none if it is empty). A run is replayed from a
// two-bank payload store byte by byte (a store read, then the beat into a four-deep output
// queue). in_full rises while a third frame's payload would need a bank whose run is still
// being delivered, or while the end-of-frame byte waits for room in the two-entry command queue.
// Configuration writes are always taken (cfg_ready is high); they act at the next frame's end check.
module crc_checked_frame_deframer_unit import cdfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_rx_byte,
  output logic       in_full,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_status,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_byte_index,
  output logic [7:0] out_frame_type,
  output logic [6:0] out_frame_length,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] accept_type_r;
  logic [6:0] accept_length_r;

  logic      cmdq_full, cmdq_empty, cmd_push, cmd_pop;
  cmd_t      cmd_in, cmd_head;
  store_wr_t wr;
  bank_rel_t rel;
  logic      res_push, res_full;
  result_t   res, res_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_type_r   <= ACCEPT_TYPE_RST;
      accept_length_r <= ACCEPT_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACCEPT_TYPE:   accept_type_r   <= cfg_data;
        REG_ACCEPT_LENGTH: accept_length_r <= cfg_data[6:0];
        default:           accept_type_r   <= accept_type_r;
      endcase
    end
  end

  cdfd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_rx_byte    (in_rx_byte),
    .in_full       (in_full),
    .accept_type   (accept_type_r),
    .accept_length (accept_length_r),
    .cmdq_full     (cmdq_full),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .wr            (wr),
    .rel           (rel)
  );

  cdfd_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .full     (cmdq_full),
    .pop      (cmd_pop),
    .head     (cmd_head),
    .empty    (cmdq_empty)
  );

  cdfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .cmd       (cmd_head),
    .cmd_empty (cmdq_empty),
    .cmd_pop   (cmd_pop),
    .rel       (rel),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  cdfd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_res (res),
    .full     (res_full),
    .pop      (out_pop),
    .head     (res_head),
    .empty    (out_empty)
  );

  assign out_status       = res_head.status;
  assign out_payload_byte = res_head.payload_byte;
  assign out_byte_index   = res_head.byte_index;
  assign out_frame_type   = res_head.frame_type;
  assign out_frame_length = res_head.frame_length;
  assign out_last         = res_head.last;

  a_single_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_PAYLOAD) |-> out_last)
    else $error("error or ignored result without last");

  a_single_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_PAYLOAD) |->
      (out_payload_byte == 8'd0 && out_byte_index == 6'd0))
    else $error("non-payload result carries payload fields");

  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_PAYLOAD) |-> ({1'b0, out_byte_index} < out_frame_length))
    else $error("payload index beyond frame length");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_PAYLOAD && out_last) |->
      ({1'b0, out_byte_index} + 7'd1 == out_frame_length))
    else $error("last set before the final payload byte");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status == ST_PAYLOAD || out_status == ST_CRC_ERR ||
                    out_status == ST_IGNORED))
    else $error("unknown status code at output");

endmodule
